// ===== rtl/rld_pkg.sv =====
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the range-list decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

  localparam int AddrW    = 64;
  localparam int ByteW    = 8;
  localparam int AbW      = 4;
  localparam int CountW   = 4;
  localparam int ShiftW   = 7;
  localparam int KindW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;
  localparam int OutDataW = 2 * AddrW;

  typedef enum logic [1:0] {
    PH_KIND   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_RANGE    = 2'd0,
    ST_END      = 2'd1,
    ST_BAD_KIND = 2'd2
  } status_t;

  localparam logic [ByteW-1:0] KIND_END_CODE = 8'd0;
  localparam logic [ByteW-1:0] KIND_MAX_CODE = 8'd7;

  localparam logic [KindW-1:0] KIND_NONE        = 3'd0;
  localparam logic [KindW-1:0] KIND_BASEX       = 3'd1;
  localparam logic [KindW-1:0] KIND_OFFSET_PAIR = 3'd4;
  localparam logic [KindW-1:0] KIND_BASE_ADDR   = 3'd5;
  localparam logic [KindW-1:0] KIND_START_END   = 3'd6;
  localparam logic [KindW-1:0] KIND_START_LEN   = 3'd7;

  localparam logic [CfgIdxW-1:0] CFG_DWARF5     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ADDR_BYTES = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CU_BASE    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LITTLE_END = 2'd3;

  localparam logic [AbW-1:0]    ADDR_BYTES_RST = 4'd8;
  localparam logic [ShiftW-1:0] ULEB_STEP      = 7'd7;

endpackage

// ===== rtl/range_list_decoder_core.sv =====
// ----------------------------------------------------------------------------
// range_list_decoder_core
// Range-list byte stream decoder: one byte a beat, one result beat per range,
// end or bad-kind entry, version 4 address pairs or version 5 kind-coded entries.
// ----------------------------------------------------------------------------
// Result: registered; the result beat is valid in the cycle after its input beat is accepted.
// Throughput: 1 byte per cycle while the output is not stalled; the parse
//   state registers and the result register are separate, so input is taken
//   while a result waits unless that result is stalled by m_axis_tready.
// Reset: synchronous, clears parse state, base, halt flag and output valid,
//   and loads the register reset values.
module range_list_decoder_core #(
  parameter int MAX_ADDR_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rld_pkg::ByteW-1:0]      s_axis_tdata,   // [7:0] data_byte
  input  logic                           s_axis_tuser,   // [0] list_start
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rld_pkg::OutDataW-1:0]   m_axis_tdata,   // [63:0] range_low, [127:64] range_high
  output logic [1:0]                     m_axis_tuser,   // [1:0] status
  input  logic                           cfg_wr_en,
  input  logic [rld_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [rld_pkg::CfgDataW-1:0]   cfg_data
);
  import rld_pkg::*;

  logic             dwarf5_mode;
  logic [AbW-1:0]   address_bytes;
  logic [AddrW-1:0] cu_base_address;
  logic             little_endian;

  phase_t            parse_phase, parse_phase_next;
  logic [KindW-1:0]  record_kind, record_kind_next;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [AddrW-1:0]  field_accumulator, field_accumulator_next;
  logic [ShiftW-1:0] shift_position, shift_position_next;
  logic [AddrW-1:0]  first_value, first_value_next;
  logic [AddrW-1:0]  current_base, current_base_next;
  logic              halted, halted_next;

  phase_t            eff_phase;
  logic [KindW-1:0]  eff_kind;
  logic [AddrW-1:0]  eff_first;
  logic [AddrW-1:0]  eff_base;
  logic              eff_halted;

  logic [ByteW-1:0]  b;
  logic              accept;
  logic [AbW-1:0]    addr_len;
  logic [AddrW-1:0]  addr_mask;
  logic              run_operand;
  phase_t            idx;
  logic              is_addr;
  logic [AddrW-1:0]  op_acc;
  logic [CountW-1:0] op_cnt;
  logic [ShiftW-1:0] op_shift;
  logic [AddrW-1:0]  acc_new;
  logic [CountW-1:0] cnt_new;
  logic [ShiftW-1:0] shift_new;
  logic              done;

  logic              emit;
  status_t           emit_status;
  logic              lo_add_base;
  logic [AddrW-1:0]  lo_a, hi_a, hi_b;
  logic [AddrW-1:0]  emit_low, emit_high;

  logic              out_valid;
  logic [AddrW-1:0]  out_low, out_high;
  status_t           out_status;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (address_bytes == '0) begin
      addr_len = AbW'(1);
    end else if (address_bytes > AbW'(MAX_ADDR_BYTES)) begin
      addr_len = AbW'(MAX_ADDR_BYTES);
    end else begin
      addr_len = address_bytes;
    end
  end

  always_comb begin
    for (int j = 0; j < AddrW / ByteW; j++) begin
      addr_mask[j*ByteW +: ByteW] = (AbW'(j) < addr_len) ? '1 : '0;
    end
  end

  always_comb begin
    if (s_axis_tuser) begin
      eff_phase  = PH_KIND;
      eff_kind   = KIND_NONE;
      eff_first  = '0;
      eff_base   = cu_base_address;
      eff_halted = 1'b0;
      op_acc     = '0;
      op_cnt     = '0;
      op_shift   = '0;
    end else begin
      eff_phase  = parse_phase;
      eff_kind   = record_kind;
      eff_first  = first_value;
      eff_base   = current_base;
      eff_halted = halted;
      op_acc     = field_accumulator;
      op_cnt     = byte_count;
      op_shift   = shift_position;
    end
    if (eff_phase == PH_KIND) begin
      op_acc   = '0;
      op_cnt   = '0;
      op_shift = '0;
    end
  end

  assign idx = (eff_phase == PH_KIND) ? PH_FIRST : eff_phase;

  always_comb begin
    is_addr = !dwarf5_mode || eff_kind == KIND_BASE_ADDR || eff_kind == KIND_START_END ||
              (eff_kind == KIND_START_LEN && idx == PH_FIRST);
    acc_new   = op_acc;
    cnt_new   = op_cnt;
    shift_new = op_shift;
    if (is_addr) begin
      if (little_endian) begin
        acc_new = op_acc | (AddrW'(b) << {op_cnt[2:0], 3'b000});
      end else begin
        acc_new = {op_acc[AddrW-ByteW-1:0], b};
      end
      cnt_new = op_cnt + CountW'(1);
      done    = cnt_new >= addr_len;
    end else begin
      if (!op_shift[ShiftW-1]) begin
        acc_new   = op_acc | (AddrW'(b[ByteW-2:0]) << op_shift[ShiftW-2:0]);
        shift_new = op_shift + ULEB_STEP;
      end
      done = !b[ByteW-1];
    end
  end

  always_comb begin
    parse_phase_next       = eff_phase;
    record_kind_next       = eff_kind;
    byte_count_next        = op_cnt;
    field_accumulator_next = op_acc;
    shift_position_next    = op_shift;
    first_value_next       = eff_first;
    current_base_next      = eff_base;
    halted_next            = eff_halted;
    run_operand            = 1'b0;
    emit                   = 1'b0;
    emit_status            = ST_RANGE;
    lo_add_base            = 1'b0;
    hi_a                   = '0;
    hi_b                   = '0;
    if (!eff_halted) begin
      if (eff_phase == PH_KIND) begin
        if (dwarf5_mode) begin
          if (b == KIND_END_CODE) begin
            emit        = 1'b1;
            emit_status = ST_END;
            halted_next = 1'b1;
          end else if (b > KIND_MAX_CODE) begin
            emit        = 1'b1;
            emit_status = ST_BAD_KIND;
            halted_next = 1'b1;
          end else begin
            record_kind_next = b[KindW-1:0];
            parse_phase_next = PH_FIRST;
          end
        end else begin
          run_operand = 1'b1;
        end
      end else begin
        run_operand = 1'b1;
      end
      if (run_operand) begin
        if (!done) begin
          parse_phase_next       = idx;
          field_accumulator_next = acc_new;
          byte_count_next        = cnt_new;
          shift_position_next    = shift_new;
        end else begin
          field_accumulator_next = '0;
          byte_count_next        = '0;
          shift_position_next    = '0;
          if (!dwarf5_mode) begin
            if (idx == PH_FIRST) begin
              first_value_next = acc_new;
              parse_phase_next = PH_SECOND;
            end else begin
              parse_phase_next = PH_KIND;
              if (eff_first == '0 && acc_new == '0) begin
                emit        = 1'b1;
                emit_status = ST_END;
                halted_next = 1'b1;
              end else if (eff_first == addr_mask) begin
                current_base_next = acc_new;
              end else begin
                emit        = 1'b1;
                lo_add_base = 1'b1;
                hi_a        = acc_new;
                hi_b        = eff_base;
              end
            end
          end else if (idx == PH_FIRST && eff_kind != KIND_BASEX &&
                       eff_kind != KIND_BASE_ADDR) begin
            first_value_next = acc_new;
            parse_phase_next = PH_SECOND;
          end else begin
            parse_phase_next = PH_KIND;
            case (eff_kind)
              KIND_OFFSET_PAIR: begin
                emit        = 1'b1;
                lo_add_base = 1'b1;
                hi_a        = acc_new;
                hi_b        = eff_base;
              end
              KIND_BASE_ADDR: current_base_next = acc_new;
              KIND_START_END: begin
                emit = 1'b1;
                hi_a = acc_new;
              end
              KIND_START_LEN: begin
                emit = 1'b1;
                hi_a = acc_new;
                hi_b = eff_first;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    lo_a = lo_add_base ? eff_base : '0;
    if (emit_status == ST_RANGE) begin
      emit_low  = eff_first + lo_a;
      emit_high = hi_a + hi_b;
    end else begin
      emit_low  = '0;
      emit_high = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwarf5_mode     <= 1'b0;
      address_bytes   <= ADDR_BYTES_RST;
      cu_base_address <= '0;
      little_endian   <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DWARF5:     dwarf5_mode     <= cfg_data[0];
        CFG_ADDR_BYTES: address_bytes   <= cfg_data[AbW-1:0];
        CFG_CU_BASE:    cu_base_address <= cfg_data[AddrW-1:0];
        CFG_LITTLE_END: little_endian   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_KIND;
      record_kind       <= '0;
      byte_count        <= '0;
      field_accumulator <= '0;
      shift_position    <= '0;
      first_value       <= '0;
      current_base      <= '0;
      halted            <= 1'b0;
    end else if (accept) begin
      parse_phase       <= parse_phase_next;
      record_kind       <= record_kind_next;
      byte_count        <= byte_count_next;
      field_accumulator <= field_accumulator_next;
      shift_position    <= shift_position_next;
      first_value       <= first_value_next;
      current_base      <= current_base_next;
      halted            <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_low    <= emit_low;
      out_high   <= emit_high;
      out_status <= emit_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_high, out_low};
  assign m_axis_tuser  = out_status;

endmodule

// ===== rtl/rld_checker.sv =====
// ----------------------------------------------------------------------------
// rld_checker
// Port-level checks for the range-list decoder, bound to range_list_decoder_core.
// ----------------------------------------------------------------------------
module rld_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [rld_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                   m_axis_tuser
);
  import rld_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_END || m_axis_tuser == ST_BAD_KIND) |->
      m_axis_tdata == '0)
    else $error("end or error beat carries a nonzero range");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      $past(s_axis_tvalid && s_axis_tready) || $past(m_axis_tvalid && !m_axis_tready))
    else $error("result beat without an accepted input beat");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input held off with the output stage empty");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result beat right after reset");

endmodule

bind range_list_decoder_core rld_checker u_rld_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
